/* rtl/rmq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int WORD_W_DEF = 32;
  localparam int FRAC_B_DEF = 30;

  // pivot selection codes
  localparam logic [1:0] PIV_W = 2'd0;
  localparam logic [1:0] PIV_X = 2'd1;
  localparam logic [1:0] PIV_Y = 2'd2;
  localparam logic [1:0] PIV_Z = 2'd3;

endpackage : rmq_pkg
`default_nettype wire

/* rtl/rotation_matrix_to_quaternion.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion by the pivot method.
// ----------------------------------------------------------------------------
// One request per cycle, fully pipelined; a stall freezes the whole pipe. A request
// passes the front registers, the bit-serial square root (one result bit per stage,
// SN = (WORD_WIDTH+FRAC_BITS+1)/2 stages), three parallel restoring dividers (one
// quotient bit per stage, QN = WORD_WIDTH+FRAC_BITS+3 stages) and the output register.
// A two-entry skid stage at the output takes a request while a finished result
// waits, so in_tready comes from the skid count alone and drops only when both
// entries are full. A non-positive square-root argument yields zero components
// with invalid set.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_W_DEF,
  parameter int FRAC_BITS  = FRAC_B_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  wire [9*WORD_WIDTH-1:0]   in_tdata,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  // q_w, q_x, q_y, q_z from bit 0 up
  output logic [4*WORD_WIDTH-1:0]  out_tdata,
  // invalid
  output logic                     out_tuser
);

  localparam int W   = WORD_WIDTH;
  localparam int EW  = W + 3;            // element sums, exact
  localparam int RW  = W + FRAC_BITS;    // radicand width (arg << FRAC-2 fits)
  localparam int SN  = (RW + 1) / 2;     // sqrt result bits
  localparam int SRW = 2 * SN;           // padded radicand
  localparam int NW  = EW + FRAC_BITS;   // numerator magnitude width
  localparam int QN  = NW;               // quotient bits
  localparam int DL  = SN + QN;          // stages after front
  localparam int TOT = 3 + DL + 1;
  localparam int OW  = QN + 1;

  // --------------------------------------------------------------------------
  // global stall: pipeline advances when skid buffer has room
  // --------------------------------------------------------------------------
  logic adv;
  logic [1:0] sk_cnt_r;
  logic [TOT-1:0] v_r;
  assign adv = (sk_cnt_r != 2'd2);
  assign in_tready = adv;

  // stage 0: register inputs
  logic signed [W-1:0] m_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 9; n++) m_r[n] <= $signed(in_tdata[n*W +: W]);
    end
  end

  // stage 1: trace, pivot choice, argument and numerators
  logic signed [EW-1:0] tr, dg, arg, a01, a02, a12, s01, s02, s12;
  logic [1:0] piv;
  logic [1:0] imx;
  always_comb begin
    tr = EW'(m_r[0]) + EW'(m_r[4]) + EW'(m_r[8]);
    imx = 2'd0;
    dg = EW'(m_r[0]);
    if (m_r[4] > m_r[0]) begin
      imx = 2'd1; dg = EW'(m_r[4]);
    end
    if (EW'(m_r[8]) > dg) begin
      imx = 2'd2; dg = EW'(m_r[8]);
    end
    if (tr > dg) begin
      piv = PIV_W;
      arg = (EW'(1) <<< FRAC_BITS) + tr;
    end else begin
      piv = imx + 2'd1;
      arg = (dg <<< 1) + (EW'(1) <<< FRAC_BITS) - tr;
    end
    a01 = EW'(m_r[1]) + EW'(m_r[3]);
    a02 = EW'(m_r[2]) + EW'(m_r[6]);
    a12 = EW'(m_r[5]) + EW'(m_r[7]);
    s01 = EW'(m_r[3]) - EW'(m_r[1]);  // m10-m01
    s02 = EW'(m_r[2]) - EW'(m_r[6]);  // m02-m20
    s12 = EW'(m_r[7]) - EW'(m_r[5]);  // m21-m12
  end

  logic signed [EW-1:0] n_r [3];  // numerators for the three non-pivot slots
  logic signed [EW-1:0] arg1_r;
  logic [1:0] piv1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      arg1_r <= arg;
      piv1_r <= piv;
      unique case (piv)
        PIV_W: begin n_r[0] <= s12; n_r[1] <= s02; n_r[2] <= s01; end
        PIV_X: begin n_r[0] <= s12; n_r[1] <= a01; n_r[2] <= a02; end
        PIV_Y: begin n_r[0] <= s02; n_r[1] <= a01; n_r[2] <= a12; end
        default: begin n_r[0] <= s01; n_r[1] <= a02; n_r[2] <= a12; end
      endcase
    end
  end

  // stage 2: radicand and magnitudes
  logic [SRW-1:0] rad2_r;
  logic           inv2_r;
  logic [1:0]     piv2_r;
  logic [NW-1:0]  mag2_r [3];
  logic [2:0]     neg2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      inv2_r <= (arg1_r <= 0);
      rad2_r <= SRW'($unsigned(arg1_r[EW-2:0])) << (FRAC_BITS - 2);
      piv2_r <= piv1_r;
      for (int n = 0; n < 3; n++) begin
        neg2_r[n] <= n_r[n][EW-1];
        mag2_r[n] <= NW'(n_r[n][EW-1] ? $unsigned(-n_r[n]) : $unsigned(n_r[n]))
                     << (FRAC_BITS - 2);
      end
    end
  end

  // square root: one result bit per stage
  logic [SRW-1:0] sq_rem_r [SN+1];
  logic [SN-1:0]  sq_res_r [SN+1];
  logic [SRW-1:0] sq_rad_r [SN+1];
  logic           sq_inv_r [SN+1];
  logic [1:0]     sq_piv_r [SN+1];
  logic [NW-1:0]  sq_mag_r [SN+1][3];
  logic [2:0]     sq_neg_r [SN+1];
  always_comb begin
    sq_rem_r[0] = '0;
    sq_res_r[0] = '0;
    sq_rad_r[0] = rad2_r;
    sq_inv_r[0] = inv2_r;
    sq_piv_r[0] = piv2_r;
    sq_neg_r[0] = neg2_r;
    for (int n = 0; n < 3; n++) sq_mag_r[0][n] = mag2_r[n];
  end
  for (genvar s = 0; s < SN; s++) begin : g_sq
    logic [SRW+1:0] rm, tri_v;
    always_comb begin
      rm    = {sq_rem_r[s], sq_rad_r[s][SRW-1 -: 2]};
      tri_v = (SRW+2)'({sq_res_r[s], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rm >= tri_v) begin
          sq_rem_r[s+1] <= SRW'(rm - tri_v);
          sq_res_r[s+1] <= {sq_res_r[s][SN-2:0], 1'b1};
        end else begin
          sq_rem_r[s+1] <= SRW'(rm);
          sq_res_r[s+1] <= {sq_res_r[s][SN-2:0], 1'b0};
        end
        sq_rad_r[s+1] <= sq_rad_r[s] << 2;
        sq_inv_r[s+1] <= sq_inv_r[s];
        sq_piv_r[s+1] <= sq_piv_r[s];
        sq_neg_r[s+1] <= sq_neg_r[s];
        for (int n = 0; n < 3; n++) sq_mag_r[s+1][n] <= sq_mag_r[s][n];
      end
    end
  end

  // three restoring dividers: one quotient bit per stage
  logic [SN:0]   dv_rem_r [QN+1][3];
  logic [NW-1:0] dv_num_r [QN+1][3];
  logic [SN-1:0] dv_dvs_r [QN+1];
  logic          dv_inv_r [QN+1];
  logic [1:0]    dv_piv_r [QN+1];
  logic [2:0]    dv_neg_r [QN+1];
  always_comb begin
    dv_dvs_r[0] = sq_res_r[SN];
    dv_inv_r[0] = sq_inv_r[SN];
    dv_piv_r[0] = sq_piv_r[SN];
    dv_neg_r[0] = sq_neg_r[SN];
    for (int n = 0; n < 3; n++) begin
      dv_rem_r[0][n] = '0;
      dv_num_r[0][n] = sq_mag_r[SN][n];
    end
  end
  for (genvar s = 0; s < QN; s++) begin : g_dv
    logic [SN+1:0] tr3 [3];
    always_comb begin
      for (int n = 0; n < 3; n++)
        tr3[n] = {dv_rem_r[s][n], dv_num_r[s][n][NW-1]} - (SN+2)'(dv_dvs_r[s]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int n = 0; n < 3; n++) begin
          // remainder stays below divisor, quotient bit shifts into num LSB
          if (!tr3[n][SN+1]) begin
            dv_rem_r[s+1][n] <= tr3[n][SN:0];
            dv_num_r[s+1][n] <= {dv_num_r[s][n][NW-2:0], 1'b1};
          end else begin
            dv_rem_r[s+1][n] <= {dv_rem_r[s][n][SN-1:0], dv_num_r[s][n][NW-1]};
            dv_num_r[s+1][n] <= {dv_num_r[s][n][NW-2:0], 1'b0};
          end
        end
        dv_dvs_r[s+1] <= dv_dvs_r[s];
        dv_inv_r[s+1] <= dv_inv_r[s];
        dv_piv_r[s+1] <= dv_piv_r[s];
        dv_neg_r[s+1] <= dv_neg_r[s];
      end
    end
  end

  // final stage: place components, fix sign, saturate, zero invalid results
  function automatic logic [W-1:0] sat_f(input logic signed [OW:0] v);
    logic signed [OW:0] hi, lo;
    hi = (OW+1)'((OW+1)'(1) << (W-1)) - 1;
    lo = -hi - 1;
    if (v > hi) sat_f = W'(hi);
    else if (v < lo) sat_f = W'(lo);
    else sat_f = W'(v);
  endfunction

  logic signed [OW:0] c [4];
  logic signed [OW:0] qv [3];
  logic [4*W-1:0] res_d;
  logic           inv_d;
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      qv[n] = (OW+1)'(dv_num_r[QN][n]);
      if (dv_neg_r[QN][n]) qv[n] = -qv[n];
    end
    for (int n = 0; n < 4; n++) c[n] = '0;
    unique case (dv_piv_r[QN])
      PIV_W: begin
        c[0] = (OW+1)'(dv_dvs_r[QN]); c[1] = qv[0]; c[2] = qv[1]; c[3] = qv[2];
      end
      PIV_X: begin
        c[1] = (OW+1)'(dv_dvs_r[QN]); c[0] = qv[0]; c[2] = qv[1]; c[3] = qv[2];
      end
      PIV_Y: begin
        c[2] = (OW+1)'(dv_dvs_r[QN]); c[0] = qv[0]; c[1] = qv[1]; c[3] = qv[2];
      end
      default: begin
        c[3] = (OW+1)'(dv_dvs_r[QN]); c[0] = qv[0]; c[1] = qv[1]; c[2] = qv[2];
      end
    endcase
    if (c[0] < 0) begin
      for (int n = 0; n < 4; n++) c[n] = -c[n];
    end
    inv_d = dv_inv_r[QN];
    for (int n = 0; n < 4; n++)
      res_d[n*W +: W] = inv_d ? '0 : sat_f(c[n]);
  end

  logic [4*W-1:0] res_r;
  logic           inv_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_d;
      inv_r <= inv_d;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[TOT-2:0], in_tvalid};
    end
  end

  // two-entry output skid queue
  logic [4*W:0] sk_r [2];
  logic         push, pop;
  assign push = adv && v_r[TOT-1];
  assign pop  = out_tvalid && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_cnt_r <= 2'd0;
    end else begin
      sk_cnt_r <= sk_cnt_r + 2'(push) - 2'(pop);
    end
  end
  // push with pop only happens with one entry held
  always_ff @(posedge clk) begin
    if (pop) begin
      sk_r[0] <= push ? {inv_r, res_r} : sk_r[1];
    end else if (push) begin
      sk_r[sk_cnt_r[0]] <= {inv_r, res_r};
    end
  end
  assign out_tvalid = (sk_cnt_r != 2'd0);
  assign out_tdata  = sk_r[0][4*W-1:0];
  assign out_tuser  = sk_r[0][4*W];

endmodule : rotation_matrix_to_quaternion
`default_nettype wire

/* rtl/rmq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int WORD_WIDTH = WORD_W_DEF
) (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_tready,
  input wire                     out_tvalid,
  input wire                     out_tready,
  input wire [4*WORD_WIDTH-1:0]  out_tdata,
  input wire                     out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("invalid result not zero");

  a_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[WORD_WIDTH-1])
    else $error("q_w negative");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with output empty");

endmodule : rmq_checker

bind rotation_matrix_to_quaternion rmq_checker #(.WORD_WIDTH(WORD_WIDTH)) u_rmq_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
